// ===== hdl/mpq_pkg.sv =====
// ============================================================================
// mpq_pkg
// Types, codes and defaults shared by the min priority queue unit.
// ============================================================================
`default_nettype none

package mpq_pkg;

    localparam int DATA_W           = 32;
    localparam int COUNT_W          = 7;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 64;

    // Operation codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } t_out;

    // One stored queue entry, one memory word
    typedef struct packed {
        logic signed [DATA_W-1:0] pri;
        logic signed [DATA_W-1:0] value;
    } t_entry;

endpackage

`default_nettype wire

// ===== hdl/min_priority_queue_unit.sv =====
// ============================================================================
// min_priority_queue_unit
// Bounded min priority queue kept as an unsorted array in one RAM.
// ============================================================================
// Push, pop on empty and push on full: busy stays low and the result strobes
//   in the cycle after the transaction, so these run at one per cycle.
// Pop: busy while the scan state reads every entry, one RAM read each, and the
//   shift state moves the later entries down; the result strobes in the first
//   cycle with busy low, when the next transaction may already be taken.
// Results cannot be stalled. Synchronous reset empties the queue, not the RAM.
`default_nettype none

module min_priority_queue_unit #(
    parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mpq_pkg::t_in  i_item,
    output logic               o_result_strobe,
    output mpq_pkg::t_out      o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [AW-1:0]                   r_cmp, n_cmp;
    logic [AW-1:0]                   r_best, n_best;
    logic signed [mpq_pkg::DATA_W-1:0] r_best_pri, n_best_pri;
    logic signed [mpq_pkg::DATA_W-1:0] r_best_val, n_best_val;
    logic [AW-1:0]                   r_wr, n_wr;
    logic                            r_strobe, n_strobe;
    mpq_pkg::t_out                   r_res, n_res;

    logic                                 ram_we;
    logic [AW-1:0]                        ram_waddr;
    logic [AW-1:0]                        ram_raddr;
    logic [$bits(mpq_pkg::t_entry)-1:0]   ram_wdata;
    logic [$bits(mpq_pkg::t_entry)-1:0]   ram_rdata;
    mpq_pkg::t_entry                      rd_entry;
    mpq_pkg::t_entry                      push_entry;

    logic          take;
    logic          finish;
    logic          full;
    logic [AW-1:0] last_idx;

    mpq_ram #(
        .WIDTH ($bits(mpq_pkg::t_entry)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry         = mpq_pkg::t_entry'(ram_rdata);
    assign push_entry.pri   = i_item.item_priority;
    assign push_entry.value = i_item.item_value;
    assign full             = (r_count == CW'(CAPACITY));
    assign last_idx         = AW'(r_count - 1'b1);
    // first entry seeds the minimum; strict compare keeps the earliest on ties
    assign take             = (r_cmp == '0) || (rd_entry.pri < r_best_pri);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cmp      = r_cmp;
        n_best     = r_best;
        n_best_pri = r_best_pri;
        n_best_val = r_best_val;
        n_wr       = r_wr;
        n_strobe   = 1'b0;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = r_wr;
        ram_wdata  = ram_rdata;
        ram_raddr  = AW'(r_cmp + 1'b1);
        finish     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = '0;
                if (start) begin
                    if (i_item.action == mpq_pkg::ACT_PUSH) begin
                        n_strobe           = 1'b1;
                        n_res.popped_value = '0;
                        if (full) begin
                            n_res.status = mpq_pkg::STATUS_PUSH_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            ram_waddr    = AW'(r_count);
                            ram_wdata    = push_entry;
                            n_count      = r_count + 1'b1;
                            n_res.status = mpq_pkg::STATUS_OK;
                        end
                        n_res.count    = mpq_pkg::COUNT_W'(n_count);
                        n_res.is_empty = (n_count == '0);
                    end else if (r_count == '0) begin
                        n_strobe           = 1'b1;
                        n_res.popped_value = '0;
                        n_res.status       = mpq_pkg::STATUS_POP_EMPTY;
                        n_res.count        = mpq_pkg::COUNT_W'(r_count);
                        n_res.is_empty     = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                        n_cmp   = '0;
                    end
                end
            end
            S_SCAN: begin
                if (take) begin
                    n_best     = r_cmp;
                    n_best_pri = rd_entry.pri;
                    n_best_val = rd_entry.value;
                end
                n_cmp = AW'(r_cmp + 1'b1);
                if (r_cmp == last_idx) begin
                    if (n_best == last_idx) begin
                        finish = 1'b1;
                    end else begin
                        // prefetch the entry that moves into the gap
                        n_state   = S_SHIFT;
                        n_wr      = n_best;
                        ram_raddr = AW'(n_best + 1'b1);
                    end
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr;
                ram_wdata = ram_rdata;
                ram_raddr = AW'(r_wr + AW'(2));
                n_wr      = AW'(r_wr + 1'b1);
                if (AW'(r_wr + 1'b1) == last_idx) begin
                    finish = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state            = S_IDLE;
            n_count            = r_count - 1'b1;
            n_strobe           = 1'b1;
            n_res.popped_value = n_best_val;
            n_res.status       = mpq_pkg::STATUS_OK;
            n_res.count        = mpq_pkg::COUNT_W'(n_count);
            n_res.is_empty     = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp      <= n_cmp;
        r_best     <= n_best;
        r_best_pri <= n_best_pri;
        r_best_val <= n_best_val;
        r_wr       <= n_wr;
        r_res      <= n_res;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_res;

    // A push transaction always reports on the next cycle
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == mpq_pkg::ACT_PUSH) |=> o_result_strobe)
        else $error("push transaction without result");

    // Never hold more entries than the array has
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A running pop always has something to remove
    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_count != '0))
        else $error("pop in progress on empty queue");

    // Reported empty flag agrees with the stored count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_result.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

`default_nettype wire

// ===== hdl/mpq_ram.sv =====
// ============================================================================
// mpq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module mpq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
